### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gcd_pkg.sv
package gcd_pkg;

    localparam int ANGLE_FRACTION_BITS_DEF = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_STEPS = 32;
    localparam int LAT_W = 24;
    localparam int LON_W = 25;
    localparam int DIST_W = 25;
    localparam int IN_W = 2 * LAT_W + 2 * LON_W;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((DIST_W + 7) / 8) * 8;
    // Q17 degree differences, full angles and sums all fit in 28 bits signed.
    localparam int DEG_W = 28;
    // Q30 working width for the rotation datapaths.
    localparam int CW = 34;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [26:0] PI_OVER_180_Q32 = 27'd74961321;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic [DEG_W-1:0] FULL_TURN_Q17 = 28'd47185920;
    localparam logic [23:0] TWO_RADII_METERS = 24'd12742000;

    typedef struct packed {
        logic signed [DEG_W-1:0] d_lat;
        logic signed [DEG_W-1:0] d_lon;
        logic signed [DEG_W-1:0] lat1;
        logic signed [DEG_W-1:0] lat2;
    } t_angles;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            5'd0: v = 34'sh3243F6A8;
            5'd1: v = 34'sh1DAC6705;
            5'd2: v = 34'sh0FADBAFC;
            5'd3: v = 34'sh07F56EA6;
            5'd4: v = 34'sh03FEAB76;
            5'd5: v = 34'sh01FFD55B;
            5'd6: v = 34'sh00FFFAAA;
            5'd7: v = 34'sh007FFF55;
            5'd8: v = 34'sh003FFFEA;
            5'd9: v = 34'sh001FFFFD;
            5'd10: v = 34'sh000FFFFF;
            5'd11: v = 34'sh0007FFFF;
            5'd12: v = 34'sh0003FFFF;
            5'd13: v = 34'sh0001FFFF;
            5'd14: v = 34'sh0000FFFF;
            5'd15: v = 34'sh00007FFF;
            5'd16: v = 34'sh00003FFF;
            5'd17: v = 34'sh00001FFF;
            5'd18: v = 34'sh00000FFF;
            5'd19: v = 34'sh000007FF;
            5'd20: v = 34'sh000003FF;
            5'd21: v = 34'sh000001FF;
            5'd22: v = 34'sh000000FF;
            5'd23: v = 34'sh0000007F;
            5'd24: v = 34'sh0000003F;
            5'd25: v = 34'sh0000001F;
            5'd26: v = 34'sh0000000F;
            5'd27: v = 34'sh00000008;
            5'd28: v = 34'sh00000004;
            5'd29: v = 34'sh00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [CW-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Q30 product rounded half up; operands are within [-1, 1].
    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return p[CW+29:30];
    endfunction

endpackage

### hdl/great_circle_distance_unit.sv
// Haversine great-circle distance in meters on a 6371 km sphere. One item
// is accepted per clock while the output is drained. The datapath holds
// the two 30-step CORDIC pipelines and the 32-step square-root
// pipeline. A four-entry queue decouples input from pipeline.
module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
    // second_longitude[97:73], zero fill above
    input  logic [IN_BYTES_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // distance_meters[24:0], zero fill above
    output logic [OUT_BYTES_W-1:0]  m_axis_tdata
);

    logic    q_valid;
    logic    q_ready;
    t_angles q_angles;
    logic [DIST_W-1:0] out_dist;

    gcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_lat1   (s_axis_tdata[23:0]),
        .i_lon1   (s_axis_tdata[48:24]),
        .i_lat2   (s_axis_tdata[72:49]),
        .i_lon2   (s_axis_tdata[97:73]),
        .o_valid  (q_valid),
        .i_ready  (q_ready),
        .o_angles (q_angles)
    );

    gcd_back #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_angles (q_angles),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_dist   (out_dist)
    );

    assign m_axis_tdata = OUT_BYTES_W'(out_dist);

endmodule

### hdl/gcd_front.sv
// Front end: takes an item, forms the four Q17 angles and pushes them into the queue.
module gcd_front
    import gcd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [LAT_W-1:0]   i_lat1,
    input  logic signed [LON_W-1:0]   i_lon1,
    input  logic signed [LAT_W-1:0]   i_lat2,
    input  logic signed [LON_W-1:0]   i_lon2,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_angles                   o_angles
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_angles             r_mem [QUEUE_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [PW:0]         r_cnt;
    logic                push;
    logic                pop;
    t_angles             in_angles;

    // Half differences are the plain Q16 difference read as Q17.
    always_comb begin
        in_angles.d_lat = DEG_W'(i_lat2) - DEG_W'(i_lat1);
        in_angles.d_lon = DEG_W'(i_lon2) - DEG_W'(i_lon1);
        in_angles.lat1  = DEG_W'(i_lat1) <<< 1;
        in_angles.lat2  = DEG_W'(i_lat2) <<< 1;
    end

    assign o_ready  = (r_cnt != (PW+1)'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign push     = i_valid && o_ready;
    assign pop      = o_valid && i_ready;
    assign o_angles = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_angles;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

### hdl/gcd_back.sv
// Back end: pipelined CORDIC trig, products, roots, arcsine CORDIC, scaling.
// Every stage advances together under one enable; an output register and a
// skid register let the consumer stall without losing an item.
module gcd_back
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_angles             i_angles,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DIST_W-1:0]   o_dist
);

    localparam int SH = 49 - ANGLE_FRACTION_BITS;
    localparam int LS = 30 - ANGLE_FRACTION_BITS;
    // Pipeline layout.
    localparam int T0 = 2;                    // reduce, radians
    localparam int T1 = T0 + CORDIC_STEPS;    // trig done
    localparam int P0 = T1 + 2;               // products
    localparam int R0 = P0 + ROOT_STEPS;      // roots done
    localparam int A0 = R0 + CORDIC_STEPS;    // arcsine done
    localparam int NST = A0 + 1;              // scale

    logic advance;
    logic [NST-1:0] r_v;

    // Output side with skid.
    logic [DIST_W-1:0] r_out;
    logic              r_out_v;
    logic [DIST_W-1:0] r_skid;
    logic              r_skid_v;

    assign advance = !r_skid_v;
    assign o_ready = advance;
    assign o_valid = r_out_v;
    assign o_dist  = r_out;

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (advance) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // ---- Stage 0: reduce four angles to [0,90] degrees.
    logic [DEG_W-1:0] r_red [4];
    logic             r_neg0 [4];
    logic signed [DEG_W-1:0] ang [4];
    assign ang[0] = i_angles.d_lat;
    assign ang[1] = i_angles.d_lon;
    assign ang[2] = i_angles.lat1;
    assign ang[3] = i_angles.lat2;

    for (genvar k = 0; k < 4; k++) begin : g_red
        logic signed [DEG_W:0] m;
        logic [DEG_W-1:0] r1;
        logic [DEG_W-1:0] r2;
        logic [DEG_W-1:0] r3;
        logic ng;
        // Values stay below one turn in magnitude, so the conditional steps wrap them.
        always_comb begin
            m = (DEG_W+1)'(ang[k]);
            if (m < 0) m = m + (DEG_W+1)'(FULL_TURN_Q17);
            if (m < 0) m = m + (DEG_W+1)'(FULL_TURN_Q17);
            if (m >= (DEG_W+1)'(FULL_TURN_Q17)) m = m - (DEG_W+1)'(FULL_TURN_Q17);
            if (m >= (DEG_W+1)'(FULL_TURN_Q17)) m = m - (DEG_W+1)'(FULL_TURN_Q17);
            r1 = m[DEG_W-1:0];
            r2 = (r1 > (FULL_TURN_Q17 >> 1)) ? FULL_TURN_Q17 - r1 : r1;
            ng = (r2 > (FULL_TURN_Q17 >> 2));
            r3 = ng ? (FULL_TURN_Q17 >> 1) - r2 : r2;
        end
        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_red[k]  <= r3;
                r_neg0[k] <= ng;
            end
        end
    end

    // ---- Stage 1: degrees to Q30 radians.
    logic signed [CW-1:0] r_z1 [4];
    logic                 r_neg1 [4];
    for (genvar k = 0; k < 4; k++) begin : g_rad
        logic [55:0] prod;
        logic [55:0] rad;
        always_comb begin
            prod = 56'(r_red[k]) * 56'(PI_OVER_180_Q32) + (56'd1 << (SH - 1));
            rad  = prod >> SH;
        end
        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_z1[k]   <= CW'(rad) <<< LS;
                r_neg1[k] <= r_neg0[k];
            end
        end
    end

    // ---- Trig CORDIC stages: four lanes each.
    logic signed [CW-1:0] tx [CORDIC_STEPS+1][4];
    logic signed [CW-1:0] ty [CORDIC_STEPS+1][4];
    logic signed [CW-1:0] tz [CORDIC_STEPS+1][4];
    logic                 tn [CORDIC_STEPS+1][4];
    for (genvar k = 0; k < 4; k++) begin : g_tin
        assign tx[0][k] = CORDIC_GAIN_Q30;
        assign ty[0][k] = '0;
        assign tz[0][k] = r_z1[k];
        assign tn[0][k] = r_neg1[k];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_trig
        logic signed [CW-1:0] r_x [4];
        logic signed [CW-1:0] r_y [4];
        logic signed [CW-1:0] r_z [4];
        for (genvar k = 0; k < 4; k++) begin : g_l
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic                 r_n;
            assign dx = tx[i][k] >>> i;
            assign dy = ty[i][k] >>> i;
            always_ff @(posedge i_clk) begin
                if (advance) begin
                    r_n <= tn[i][k];
                    if (tz[i][k] >= 0) begin
                        r_x[k] <= tx[i][k] - dy;
                        r_y[k] <= ty[i][k] + dx;
                        r_z[k] <= tz[i][k] - atan_q30(5'(i));
                    end else begin
                        r_x[k] <= tx[i][k] + dy;
                        r_y[k] <= ty[i][k] - dx;
                        r_z[k] <= tz[i][k] + atan_q30(5'(i));
                    end
                end
            end
            assign tx[i+1][k] = r_x[k];
            assign ty[i+1][k] = r_y[k];
            assign tz[i+1][k] = r_z[k];
            assign tn[i+1][k] = r_n;
        end
    end

    // ---- Product stage 1: squares and cosine product.
    logic signed [CW-1:0] s_lat, s_lon, c1, c2;
    always_comb begin
        s_lat = clamp_unit(ty[CORDIC_STEPS][0]);
        s_lon = clamp_unit(ty[CORDIC_STEPS][1]);
        c1 = clamp_unit(tx[CORDIC_STEPS][2]);
        c2 = clamp_unit(tx[CORDIC_STEPS][3]);
        if (tn[CORDIC_STEPS][2]) c1 = -c1;
        if (tn[CORDIC_STEPS][3]) c2 = -c2;
    end
    logic signed [CW-1:0] r_sq_lat, r_sq_lon, r_cc;
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sq_lat <= mul_q30(s_lat, s_lat);
            r_sq_lon <= mul_q30(s_lon, s_lon);
            r_cc     <= mul_q30(c1, c2);
        end
    end

    // ---- Product stage 2: a, clamped, and the root operands.
    logic signed [CW-1:0] a_raw, a_cl;
    always_comb begin
        a_raw = r_sq_lat + mul_q30(r_sq_lon, r_cc);
        a_cl  = clamp_unit(a_raw);
    end
    logic [63:0] rn [ROOT_STEPS+1][2];
    logic [63:0] rr [ROOT_STEPS+1][2];
    logic [63:0] r_n0 [2];
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_n0[0] <= 64'(a_cl[30:0]) << 30;
            r_n0[1] <= 64'(31'(ONE_Q30 - a_cl)) << 30;
        end
    end
    assign rn[0][0] = r_n0[0];
    assign rn[0][1] = r_n0[1];
    assign rr[0][0] = '0;
    assign rr[0][1] = '0;

    // ---- Bitwise root stages, two lanes.
    for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] r_nn [2];
        logic [63:0] r_rr [2];
        for (genvar k = 0; k < 2; k++) begin : g_l
            logic [63:0] t;
            assign t = rr[i][k] + BIT;
            always_ff @(posedge i_clk) begin
                if (advance) begin
                    if (rn[i][k] >= t) begin
                        r_nn[k] <= rn[i][k] - t;
                        r_rr[k] <= (rr[i][k] >> 1) + BIT;
                    end else begin
                        r_nn[k] <= rn[i][k];
                        r_rr[k] <= rr[i][k] >> 1;
                    end
                end
            end
            assign rn[i+1][k] = r_nn[k];
            assign rr[i+1][k] = r_rr[k];
        end
    end

    // ---- Arcsine vectoring CORDIC.
    logic signed [CW-1:0] ax [CORDIC_STEPS+1];
    logic signed [CW-1:0] ay [CORDIC_STEPS+1];
    logic signed [CW-1:0] az [CORDIC_STEPS+1];
    assign ax[0] = CW'(rr[ROOT_STEPS][1]);
    assign ay[0] = CW'(rr[ROOT_STEPS][0]);
    assign az[0] = '0;
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_asin
        logic signed [CW-1:0] r_x, r_y, r_z, sx, sy;
        assign sx = ax[i] >>> i;
        assign sy = ay[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (advance) begin
                if (ay[i] >= 0) begin
                    r_x <= ax[i] + sy;
                    r_y <= ay[i] - sx;
                    r_z <= az[i] + atan_q30(5'(i));
                end else begin
                    r_x <= ax[i] - sy;
                    r_y <= ay[i] + sx;
                    r_z <= az[i] - atan_q30(5'(i));
                end
            end
        end
        assign ax[i+1] = r_x;
        assign ay[i+1] = r_y;
        assign az[i+1] = r_z;
    end

    // ---- Scale to meters.
    logic [30:0] r_theta;
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_theta <= (az[CORDIC_STEPS] < 0) ? '0 : 31'(az[CORDIC_STEPS]);
        end
    end
    logic [55:0] meters;
    logic [DIST_W-1:0] dist_val;
    always_comb begin
        meters = 56'(TWO_RADII_METERS) * 56'(r_theta) + (56'd1 << 29);
        dist_val = (meters[55:30] > 26'((1 << DIST_W) - 1)) ? '1 : meters[30+DIST_W-1:30];
    end

    // Output register and skid register.
    logic last_v;
    assign last_v = r_v[NST-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || i_ready) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= advance && last_v;
                    r_out   <= dist_val;
                end
            end else if (advance && last_v) begin
                r_skid   <= dist_val;
                r_skid_v <= 1'b1;
            end
        end
    end

endmodule

### hdl/gcd_checker.sv
`include "assert_macros.svh"

// Port-level checks on the distance unit.
module gcd_checker
    import gcd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_BYTES_W-1:0] m_axis_tdata
);

    // The distance never exceeds half the circumference.
    `CHK_ALWAYS(a_dist_max, i_clk, i_rst_n,
                !m_axis_tvalid || (m_axis_tdata <= 32'd20015087), "distance out of range")
    // Fill bits above the distance stay zero.
    `CHK_ALWAYS(a_fill, i_clk, i_rst_n,
                !m_axis_tvalid || (m_axis_tdata[OUT_BYTES_W-1:DIST_W] == '0), "fill bits set")
    // A stalled result holds.
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    // Reset leaves no result pending.
    `CHK_NEXT(a_rst, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "result after reset")

endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/tb.sv
`default_nettype none

module tb
    import gcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;
    localparam int FRAC_BITS = 16;
    localparam int DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [LAT_W-1:0] lat_a;
        logic signed [LON_W-1:0] lon_a;
        logic signed [LAT_W-1:0] lat_b;
        logic signed [LON_W-1:0] lon_b;
    } t_fix_pair;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
    // second_longitude[97:73], zero fill above
    logic [IN_BYTES_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // distance_meters[24:0], zero fill above
    logic [OUT_BYTES_W-1:0] m_axis_tdata;

    logic [DIST_W-1:0] expected_meters[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycle_count;

    great_circle_distance_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Rotation arctangent table in Q30 radians.
    function automatic longint arctan_entry(input int idx);
        longint tbl[30] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
        };
        return tbl[idx];
    endfunction

    function automatic longint unit_clamp(input longint v);
        longint one;
        one = longint'(1) << 30;
        if (v < 0) return 0;
        if (v > one) return one;
        return v;
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint isqrt_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Sine magnitude and signed cosine of a Q17 degree angle, by rotation CORDIC.
    function automatic void sin_cos_deg(input longint deg, output longint s,
                                        output longint c);
        longint turn;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint unsigned rad;
        bit flip;
        int sh;
        turn = longint'(360) << 17;
        r = deg % turn;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        sh = 49 - FRAC_BITS;
        if (r < 0) r += turn;
        if (r > turn / 2) r = turn - r;
        if (r > turn / 4) begin
            r = turn / 2 - r;
            flip = 1'b1;
        end
        rad = (longint'(r) * 74961321 + (longint'(1) << (sh - 1))) >> sh;
        z = longint'(rad << (30 - FRAC_BITS));
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_entry(i);
            end else begin
                x += dx; y -= dy; z += arctan_entry(i);
            end
        end
        x = unit_clamp(x);
        s = unit_clamp(y);
        c = flip ? -x : x;
    endfunction

    // Haversine distance in meters for one pair of fixes.
    function automatic logic [DIST_W-1:0] haversine_meters(input t_fix_pair p);
        longint la1, lo1, la2, lo2;
        longint s_lat, s_lon, c1, c2, unused, hav, x, y, z, xo;
        longint unsigned q, w, m;
        la1 = p.lat_a; lo1 = p.lon_a; la2 = p.lat_b; lo2 = p.lon_b;
        sin_cos_deg(la2 - la1, s_lat, unused);
        sin_cos_deg(lo2 - lo1, s_lon, unused);
        sin_cos_deg(la1 * 2, unused, c1);
        sin_cos_deg(la2 * 2, unused, c2);
        hav = q30_product(s_lat, s_lat)
            + q30_product(q30_product(s_lon, s_lon), q30_product(c1, c2));
        hav = unit_clamp(hav);
        q = isqrt_floor(longint'(hav) << 30);
        w = isqrt_floor(((longint'(1) << 30) - hav) << 30);
        x = longint'(w);
        y = longint'(q);
        z = 0;
        // Vectoring CORDIC yields half the central angle.
        for (int i = 0; i < 30; i++) begin
            xo = x;
            if (y >= 0) begin
                x += y >>> i; y -= xo >>> i; z += arctan_entry(i);
            end else begin
                x -= y >>> i; y += xo >>> i; z -= arctan_entry(i);
            end
        end
        if (z < 0) z = 0;
        m = (longint'(12742000) * z + (longint'(1) << 29)) >> 30;
        if (m > 33554431) m = 33554431;
        return m[DIST_W-1:0];
    endfunction

    // Sends one item, with random idle cycles before it. Valid stays high
    // after acceptance so that back-to-back items need no extra edge.
    task automatic send_pair(input t_fix_pair p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, p.lon_b, p.lat_b, p.lon_a, p.lat_a};
        expected_meters = {expected_meters, haversine_meters(p)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_fixes(input int la1, input int lo1, input int la2, input int lo2);
        t_fix_pair p;
        p.lat_a = LAT_W'(la1);
        p.lon_a = LON_W'(lo1);
        p.lat_b = LAT_W'(la2);
        p.lon_b = LON_W'(lo2);
        send_pair(p);
    endtask

    // Receiver stalls and result checking.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_meters.size() == 0) begin
                    $display("%0t: expected no result, actual %0d", $time,
                             m_axis_tdata[DIST_W-1:0]);
                    error_count++;
                end else begin
                    if (m_axis_tdata !== OUT_BYTES_W'(expected_meters[0])) begin
                        $display("%0t: distance expected %0d actual %0d", $time,
                                 expected_meters[0], m_axis_tdata);
                        error_count++;
                    end
                    void'(expected_meters.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_meters.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Extremes, poles, antimeridian, identical and antipodal points, out-of-range fields.
    task automatic test_directed();
        send_fixes(0, 0, 0, 0);
        send_fixes(LAT_MAX, 0, -LAT_MAX, 0);
        send_fixes(0, 0, 0, LON_MAX);
        send_fixes(0, -LON_MAX, 0, LON_MAX);
        send_fixes(0, LON_MAX, 0, -LON_MAX + 1);
        send_fixes(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_fixes(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_fixes(45 << 16, 90 << 16, -(45 << 16), -(90 << 16));
        send_fixes(1, 0, 0, 1);
        send_fixes(-1, -1, 0, 0);
        send_fixes(3 << 16, 5 << 16, 3 << 16, 5 << 16);
        send_fixes(0, 0, 0, (180 << 16) - 1);
        send_fixes(10 << 16, 0, (10 << 16) + 1, 0);
        // Out-of-range coordinates, full field span.
        send_fixes(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1);
        send_fixes((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24));
        send_fixes(-1, -1, -1, -1);
        send_fixes(52 << 16, 13 << 16, 40 << 16, -(74 << 16));
        wait_drained();
    endtask

    // Random pairs: mostly in range, some near neighbors, some raw fields.
    task automatic test_random(input int count);
        t_fix_pair p;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            p.lat_a = LAT_W'($urandom_range(2 * LAT_MAX) - LAT_MAX);
            p.lon_a = LON_W'($urandom_range(2 * LON_MAX) - LON_MAX);
            if (kind < 6) begin
                p.lat_b = LAT_W'($urandom_range(2 * LAT_MAX) - LAT_MAX);
                p.lon_b = LON_W'($urandom_range(2 * LON_MAX) - LON_MAX);
            end else if (kind < 8) begin
                p.lat_b = LAT_W'(p.lat_a + $signed($urandom_range(2000)) - 1000);
                p.lon_b = LON_W'(p.lon_a + $signed($urandom_range(2000)) - 1000);
            end else begin
                p.lat_a = LAT_W'($urandom);
                p.lon_a = LON_W'($urandom);
                p.lat_b = LAT_W'($urandom);
                p.lon_b = LON_W'($urandom);
            end
            send_pair(p);
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        set_idling(0, 0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_idling(0, 0);
        test_random(400);
        set_idling(48, 0);
        test_random(400);
        // Sender holds off until every result is back.
        wait_drained();
        set_idling(0, 48);
        test_random(400);
        set_idling(20, 20);
        test_random(400);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
